[hdl/polar_cartesian_converter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the polar/cartesian converter
// Shared property templates with clock, reset and a fixed failure message.
// ----------------------------------------------------------------------------
`ifndef POLAR_CARTESIAN_CONVERTER_MACROS_SVH
`define POLAR_CARTESIAN_CONVERTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define PCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pcc: same-cycle property failed");

// Consequent checked in the cycle after the antecedent
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pcc: next-cycle property failed");

`endif

[hdl/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared constants, arctangent table and control type of the CORDIC chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcc_pkg;

  // Parameter defaults
  localparam int DEF_ITERATIONS  = 16;
  localparam int DEF_COORD_WIDTH = 16;

  // Fixed-point formats
  localparam int FRAC_BITS   = 12;  // fractional bits of coordinates
  localparam int ANG_FRAC    = 8;   // extra fractional bits of angles
  localparam int ANGLE_IN_W  = 17;
  localparam int ANGLE_OUT_W = 16;
  localparam int ZW          = 26;  // angle accumulator width
  localparam int XW_GUARD    = 3;   // growth bits above coordinate + fraction
  localparam int GAIN_W      = 17;
  localparam int GAIN_Q16    = 39797;
  localparam int GAIN_SHIFT  = 16;

  // Angle units (1/128 degree)
  localparam int TURN_UNITS    = 46080;
  localparam int HALF_UNITS    = 23040;
  localparam int QUARTER_UNITS = 11520;

  // atan(2^-i) in degrees times 2^15
  localparam int TABLE_LEN = 24;
  localparam logic signed [ZW-1:0] ATAN_DEG_Q15 [TABLE_LEN] = '{
    26'sd1474560, 26'sd870484, 26'sd459940, 26'sd233473,
    26'sd117189,  26'sd58652,  26'sd29333,  26'sd14667,
    26'sd7334,    26'sd3667,   26'sd1833,   26'sd917,
    26'sd458,     26'sd229,    26'sd115,    26'sd57,
    26'sd29,      26'sd14,     26'sd7,      26'sd4,
    26'sd2,       26'sd1,      26'sd0,      26'sd0
  };

  // Control bits that travel with each point down the chain
  typedef struct packed {
    logic valid;
    logic vec_mode;  // 1: vectoring (cartesian to polar)
    logic zero;      // vectoring input at the origin
  } pcc_ctl_t;

endpackage

[hdl/pcc_cell.sv]
// ----------------------------------------------------------------------------
// pcc_cell
// One CORDIC micro-rotation with a fixed shift, registered toward the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_cell #(
  parameter int COORD_WIDTH = pcc_pkg::DEF_COORD_WIDTH,
  parameter int SHIFT       = 0,
  localparam int XW = COORD_WIDTH + pcc_pkg::FRAC_BITS + pcc_pkg::XW_GUARD,
  localparam int ZW = pcc_pkg::ZW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  pcc_pkg::pcc_ctl_t   ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output pcc_pkg::pcc_ctl_t   ctl_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ATAN = pcc_pkg::ATAN_DEG_Q15[SHIFT];

  pcc_pkg::pcc_ctl_t    ctl_q;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ZW-1:0] z_q, z_d;
  logic                 turn_neg;

  // Direction: rotation drives z to zero, vectoring drives y to zero
  always_comb begin
    turn_neg = ctl_i.vec_mode ? y_i[XW-1] : !z_i[ZW-1];
    dx       = y_i >>> SHIFT;
    dy       = x_i >>> SHIFT;
    if (turn_neg) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // Data register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

[hdl/pcc_prep.sv]
// ----------------------------------------------------------------------------
// pcc_prep
// Input stage: angle reduction and quadrant fold, or half-plane fold for
// vectoring, into the fixed-point start vector of the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_prep #(
  parameter int COORD_WIDTH = pcc_pkg::DEF_COORD_WIDTH,
  localparam int XW = COORD_WIDTH + pcc_pkg::FRAC_BITS + pcc_pkg::XW_GUARD,
  localparam int ZW = pcc_pkg::ZW,
  localparam int AW = pcc_pkg::ANGLE_IN_W + 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic                                   cmd_i,
  input  logic signed [COORD_WIDTH-1:0]          radius_i,
  input  logic signed [pcc_pkg::ANGLE_IN_W-1:0]  angle_i,
  input  logic signed [COORD_WIDTH-1:0]          coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]          coord_y_i,
  output pcc_pkg::pcc_ctl_t                      ctl_o,
  output logic signed [XW-1:0]                   x_o,
  output logic signed [XW-1:0]                   y_o,
  output logic signed [ZW-1:0]                   z_o
);

  localparam logic signed [AW-1:0] TURN_S = AW'(pcc_pkg::TURN_UNITS);
  localparam logic signed [AW-1:0] HALF_S = AW'(pcc_pkg::HALF_UNITS);
  localparam logic signed [AW-1:0] QUAR_S = AW'(pcc_pkg::QUARTER_UNITS);
  localparam logic signed [ZW-1:0] Z_HALF =
    ZW'(pcc_pkg::HALF_UNITS * (1 << pcc_pkg::ANG_FRAC));

  pcc_pkg::pcc_ctl_t    ctl_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, r_fix, cx_fix, cy_fix;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [AW-1:0] a_ext, a_red, a_fold;
  logic                 at_origin;

  always_comb begin
    // Reduce the angle into [-180, 180) degrees
    a_ext = AW'(angle_i);
    if (a_ext >= HALF_S) begin
      a_red = a_ext - TURN_S;
    end else if (a_ext < -HALF_S) begin
      a_red = a_ext + TURN_S;
    end else begin
      a_red = a_ext;
    end

    r_fix     = XW'(radius_i) <<< pcc_pkg::FRAC_BITS;
    cx_fix    = XW'(coord_x_i) <<< pcc_pkg::FRAC_BITS;
    cy_fix    = XW'(coord_y_i) <<< pcc_pkg::FRAC_BITS;
    at_origin = (coord_x_i == '0) && (coord_y_i == '0);
    a_fold    = a_red;

    if (!cmd_i) begin
      // Rotation: fold outer quadrants by a quarter turn
      if (a_red > QUAR_S) begin
        x_d    = '0;
        y_d    = r_fix;
        a_fold = a_red - QUAR_S;
      end else if (a_red < -QUAR_S) begin
        x_d    = '0;
        y_d    = -r_fix;
        a_fold = a_red + QUAR_S;
      end else begin
        x_d = r_fix;
        y_d = '0;
      end
      z_d = ZW'(a_fold) <<< pcc_pkg::ANG_FRAC;
    end else begin
      // Vectoring: move left half-plane to the right, start at 180 degrees
      if (cx_fix < 0) begin
        x_d = -cx_fix;
        y_d = -cy_fix;
        z_d = Z_HALF;
      end else begin
        x_d = cx_fix;
        y_d = cy_fix;
        z_d = '0;
      end
    end
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid    <= valid_i;
      ctl_q.vec_mode <= cmd_i;
      ctl_q.zero     <= at_origin;
    end
  end

  // Data register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

[hdl/pcc_post.sv]
// ----------------------------------------------------------------------------
// pcc_post
// Output stages: gain compensation product, then rounding, saturation,
// angle wrap and the output register of the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_post #(
  parameter int COORD_WIDTH = pcc_pkg::DEF_COORD_WIDTH,
  localparam int XW = COORD_WIDTH + pcc_pkg::FRAC_BITS + pcc_pkg::XW_GUARD,
  localparam int ZW = pcc_pkg::ZW,
  localparam int OAW = pcc_pkg::ANGLE_OUT_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  pcc_pkg::pcc_ctl_t             ctl_i,
  input  logic signed [XW-1:0]          x_i,
  input  logic signed [XW-1:0]          y_i,
  input  logic signed [ZW-1:0]          z_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic [COORD_WIDTH-1:0]        out_radius_o,
  output logic signed [OAW-1:0]         out_angle_o
);

  localparam int PW   = XW + pcc_pkg::GAIN_W;
  localparam int SH   = pcc_pkg::GAIN_SHIFT + pcc_pkg::FRAC_BITS;
  localparam int RW   = PW - SH;
  localparam int AW   = ZW - pcc_pkg::ANG_FRAC;
  localparam logic signed [pcc_pkg::GAIN_W-1:0] GAIN_S = pcc_pkg::GAIN_W'(pcc_pkg::GAIN_Q16);
  localparam logic signed [PW-1:0] P_RND = PW'(1) <<< (SH - 1);
  localparam logic signed [ZW-1:0] Z_RND = ZW'(1) <<< (pcc_pkg::ANG_FRAC - 1);
  localparam logic signed [RW-1:0] C_MAX = {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] C_MIN = {{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [AW-1:0] TURN_S = AW'(pcc_pkg::TURN_UNITS);
  localparam logic signed [AW-1:0] HALF_S = AW'(pcc_pkg::HALF_UNITS);

  // Product stage
  pcc_pkg::pcc_ctl_t    ctl_a_q;
  logic signed [PW-1:0] prod_x_q, prod_y_q;
  logic signed [ZW-1:0] z_a_q;

  // Result stage
  logic                          valid_q;
  logic signed [COORD_WIDTH-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [COORD_WIDTH-1:0]        rad_q, rad_d;
  logic signed [OAW-1:0]         ang_q, ang_d;
  logic signed [PW-1:0]          sum_x, sum_y;
  logic signed [ZW-1:0]          sum_z;
  logic signed [RW-1:0]          rx, ry;
  logic signed [AW-1:0]          a_rnd, a_wrap;
  logic signed [COORD_WIDTH-1:0] sat_x, sat_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      valid_q <= ctl_a_q.valid;
    end
  end

  // Gain compensation products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= PW'(x_i) * PW'(GAIN_S);
      prod_y_q <= PW'(y_i) * PW'(GAIN_S);
      z_a_q    <= z_i;
    end
  end

  // Round half up, saturate, wrap the angle into (-180, 180]
  always_comb begin
    sum_x = prod_x_q + P_RND;
    sum_y = prod_y_q + P_RND;
    rx    = $signed(sum_x[PW-1:SH]);
    ry    = $signed(sum_y[PW-1:SH]);

    if (rx > C_MAX) begin
      sat_x = C_MAX[COORD_WIDTH-1:0];
    end else if (rx < C_MIN) begin
      sat_x = C_MIN[COORD_WIDTH-1:0];
    end else begin
      sat_x = rx[COORD_WIDTH-1:0];
    end
    if (ry > C_MAX) begin
      sat_y = C_MAX[COORD_WIDTH-1:0];
    end else if (ry < C_MIN) begin
      sat_y = C_MIN[COORD_WIDTH-1:0];
    end else begin
      sat_y = ry[COORD_WIDTH-1:0];
    end

    sum_z = z_a_q + Z_RND;
    a_rnd = $signed(sum_z[ZW-1:pcc_pkg::ANG_FRAC]);
    if (a_rnd > HALF_S) begin
      a_wrap = a_rnd - TURN_S;
    end else if (a_rnd <= -HALF_S) begin
      a_wrap = a_rnd + TURN_S;
    end else begin
      a_wrap = a_rnd;
    end

    ox_d  = '0;
    oy_d  = '0;
    rad_d = '0;
    ang_d = '0;
    if (!ctl_a_q.vec_mode) begin
      ox_d = sat_x;
      oy_d = sat_y;
    end else if (!ctl_a_q.zero) begin
      rad_d = rx[COORD_WIDTH-1:0];
      ang_d = a_wrap[OAW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      rad_q <= rad_d;
      ang_q <= ang_d;
    end
  end

  assign valid_o      = valid_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign out_radius_o = rad_q;
  assign out_angle_o  = ang_q;

endmodule

[hdl/polar_cartesian_converter.sv]
// Registered path to result: input stage, CORDIC cells, gain product, output.
// Throughput: one point per cycle unless the output stalls; each CORDIC cell
//   in the chain works on a different point: length sets latency, not rate.
// The whole pipeline advances when the output register is empty or taken.
// Reset (rst_ni low, asynchronous) clears all valid flags; no result pending.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// polar_cartesian_converter
// Unrolled CORDIC converting points between polar and cartesian form.
// ----------------------------------------------------------------------------
module polar_cartesian_converter #(
  parameter int ITERATIONS  = pcc_pkg::DEF_ITERATIONS,
  parameter int COORD_WIDTH = pcc_pkg::DEF_COORD_WIDTH,
  localparam int IN_BITS     = 3 * COORD_WIDTH + pcc_pkg::ANGLE_IN_W,
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = 3 * COORD_WIDTH + pcc_pkg::ANGLE_OUT_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // low to high: radius_in, angle_in, coord_x, coord_y, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command: 0 polar to cartesian, 1 cartesian to polar
  input  logic                   s_axis_tuser,
  // master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // low to high: out_x, out_y, out_radius, out_angle, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int XW = COORD_WIDTH + pcc_pkg::FRAC_BITS + pcc_pkg::XW_GUARD;
  localparam int ZW = pcc_pkg::ZW;
  localparam int AI = pcc_pkg::ANGLE_IN_W;
  localparam int AO = pcc_pkg::ANGLE_OUT_W;
  localparam int CW = COORD_WIDTH;

  logic                  en;
  logic                  out_valid;
  pcc_pkg::pcc_ctl_t     ctl_c [ITERATIONS+1];
  logic signed [XW-1:0]  x_c   [ITERATIONS+1];
  logic signed [XW-1:0]  y_c   [ITERATIONS+1];
  logic signed [ZW-1:0]  z_c   [ITERATIONS+1];
  logic signed [CW-1:0]  out_x, out_y;
  logic [CW-1:0]         out_radius;
  logic signed [AO-1:0]  out_angle;

  // Global advance: output register free or being taken
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // Input stage
  pcc_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .cmd_i     (s_axis_tuser),
    .radius_i  ($signed(s_axis_tdata[CW-1:0])),
    .angle_i   ($signed(s_axis_tdata[CW+AI-1:CW])),
    .coord_x_i ($signed(s_axis_tdata[2*CW+AI-1:CW+AI])),
    .coord_y_i ($signed(s_axis_tdata[3*CW+AI-1:2*CW+AI])),
    .ctl_o     (ctl_c[0]),
    .x_o       (x_c[0]),
    .y_o       (y_c[0]),
    .z_o       (z_c[0])
  );

  // Chain of micro-rotation cells
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    pcc_cell #(
      .COORD_WIDTH(COORD_WIDTH),
      .SHIFT      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_c[i]),
      .x_i    (x_c[i]),
      .y_i    (y_c[i]),
      .z_i    (z_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .x_o    (x_c[i+1]),
      .y_o    (y_c[i+1]),
      .z_o    (z_c[i+1])
    );
  end

  // Gain, rounding and output register
  pcc_post #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .ctl_i        (ctl_c[ITERATIONS]),
    .x_i          (x_c[ITERATIONS]),
    .y_i          (y_c[ITERATIONS]),
    .z_i          (z_c[ITERATIONS]),
    .valid_o      (out_valid),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_radius_o (out_radius),
    .out_angle_o  (out_angle)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({out_angle, out_radius, out_y, out_x});

endmodule

[hdl/pcc_checker.sv]
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "polar_cartesian_converter_macros.svh"

module pcc_checker #(
  parameter int COORD_WIDTH = pcc_pkg::DEF_COORD_WIDTH,
  localparam int OUT_BITS    = 3 * COORD_WIDTH + pcc_pkg::ANGLE_OUT_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int CW = COORD_WIDTH;

  logic xy_zero, polar_zero;

  assign xy_zero    = (m_axis_tdata[2*CW-1:0] == '0);
  assign polar_zero = (m_axis_tdata[OUT_BITS-1:2*CW] == '0);

  // Stalled result stays offered
  `PCC_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // Stalled result keeps its data
  `PCC_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // Input side ready exactly when the output register can move
  `PCC_ASSERT_NOW(a_ready_rule, clk_i, rst_ni, s_axis_tvalid || !s_axis_tvalid, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // A result carries either cartesian or polar fields, never both
  `PCC_ASSERT_NOW(a_one_form, clk_i, rst_ni, m_axis_tvalid, xy_zero || polar_zero)

endmodule

bind polar_cartesian_converter pcc_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_pcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
